// ===== rtl/cds_pkg.sv =====
// ---------------------------------------------------------------------------
// Calendar date step package
// Item types, command codes and calendar helpers used by the date counter;
// its channel interface does not import them.
// ---------------------------------------------------------------------------
package cds_pkg;

   // Command codes carried by the cmd field of a request item.
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_NEXT = 2'd1;
   localparam logic [1:0] CMD_PREV = 2'd2;

   // Year range and reset date.
   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [13:0] RESET_YEAR  = 14'd2000;
   localparam logic [3:0]  RESET_MONTH = 4'd1;
   localparam logic [4:0]  RESET_DAY   = 5'd1;

   localparam logic [3:0] MONTH_FIRST = 4'd1;
   localparam logic [3:0] MONTH_FEB   = 4'd2;
   localparam logic [3:0] MONTH_LAST  = 4'd12;
   localparam logic [4:0] DAY_FIRST   = 5'd1;
   localparam logic [4:0] DAY_FEB_LEAP = 5'd29;
   localparam logic [4:0] DAY_DEC_LAST = 5'd31;

   // Divisibility by 25 on a 14-bit year: multiply by the inverse of 25
   // modulo 2^14. Multiples of 25 map onto 0 .. 16383/25 and nothing else does.
   localparam logic [13:0] INV25     = 14'd7209;
   localparam logic [13:0] MUL25_TOP = 14'd655;

   // Days per month, January first, common year.
   localparam logic [4:0] MONTH_LEN [0:11] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [1:0]  cmd;
      logic [13:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
   } cds_req_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        leap_year;
      logic        load_error;
   } cds_rsp_type;

   // Leap rule: divisible by 4 and not by 100, or divisible by 400.
   // 100 = 4 * 25 and 400 = 16 * 25, so one test by 25 serves both.
   function automatic logic cds_is_leap(input logic [13:0] year);
      logic [13:0] residue;
      logic        div25;
      logic        div4;
      logic        div16;
      residue = 14'(year * INV25);
      div25   = (residue <= MUL25_TOP);
      div4    = (year[1:0] == 2'b00);
      div16   = (year[3:0] == 4'b0000);
      return (div4 && !div25) || (div16 && div25);
   endfunction

   // Length of a month; a month outside 1 .. 12 counts as January.
   function automatic logic [4:0] cds_month_days(input logic leap, input logic [3:0] month);
      logic [3:0] idx;
      logic [4:0] days;
      if (month >= MONTH_FIRST && month <= MONTH_LAST) begin
         idx = month - MONTH_FIRST;
      end else begin
         idx = 4'd0;
      end
      days = MONTH_LEN[idx];
      if (month == MONTH_FEB && leap) begin
         days = DAY_FEB_LEAP;
      end
      return days;
   endfunction

endpackage

// ===== rtl/cds_stream_if.sv =====
// ---------------------------------------------------------------------------
// Calendar date step channel
// Valid/ready channel carrying one item of the given payload type.
// ---------------------------------------------------------------------------
interface cds_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   // The source drives the item, the sink answers with ready.
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/calendar_date_step.sv =====
// Items pass the first stage, then the result register, which offers them.
// Throughput: one item per cycle unless stalled; date register updates on accept.
// The result register is refilled in the cycle it is taken, so stalls cost no slot.
// Reset (synchronous): date becomes 2000-01-01 and both stages empty.
// ---------------------------------------------------------------------------
// Calendar date step
// Gregorian date counter with load, next-day and previous-day commands; each
// item returns the resulting date, its leap flag and a refused-load flag.
// ---------------------------------------------------------------------------
module calendar_date_step (
   input  logic                  clock,
   input  logic                  reset,
   cds_stream_if.sink            req_if,
   cds_stream_if.source          rsp_if
);
   import cds_pkg::*;

   // Date state, first stage.
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic        err_ff, err_in;
   logic        stage_valid_ff;

   // Result register, second stage.
   logic        rsp_valid_ff;
   cds_rsp_type rsp_ff, rsp_in;

   logic        rsp_free;
   logic        stage_move;
   logic        req_take;
   logic        leap_cur;
   logic [4:0]  len_cur;
   logic        leap_load;
   logic        load_ok;
   cds_req_type req;

   // Handshake: the result register frees when empty or taken this cycle.
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign stage_move   = stage_valid_ff && rsp_free;
   assign req_if.ready = !stage_valid_ff || rsp_free;
   assign req_take     = req_if.valid && req_if.ready;
   assign req          = req_if.payload;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // Facts about the current date and the date to load.
   assign leap_cur  = cds_is_leap(year_ff);
   assign len_cur   = cds_month_days(leap_cur, month_ff);
   assign leap_load = cds_is_leap(req.load_year);
   assign load_ok   = (req.load_year <= YEAR_MAX)
                   && (req.load_month >= MONTH_FIRST) && (req.load_month <= MONTH_LAST)
                   && (req.load_day >= DAY_FIRST)
                   && (req.load_day <= cds_month_days(leap_load, req.load_month));

   // Next date for the accepted item.
   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      err_in   = 1'b0;
      case (req.cmd)
         CMD_LOAD: begin
            if (load_ok) begin
               year_in  = req.load_year;
               month_in = req.load_month;
               day_in   = req.load_day;
            end else begin
               err_in = 1'b1;
            end
         end
         CMD_NEXT: begin
            if (day_ff >= len_cur) begin
               day_in = DAY_FIRST;
               if (month_ff >= MONTH_LAST) begin
                  month_in = MONTH_FIRST;
                  year_in  = (year_ff >= YEAR_MAX) ? 14'd0 : year_ff + 14'd1;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               day_in = day_ff + 5'd1;
            end
         end
         CMD_PREV: begin
            if (day_ff <= DAY_FIRST) begin
               if (month_ff <= MONTH_FIRST) begin
                  month_in = MONTH_LAST;
                  year_in  = (year_ff == 14'd0) ? YEAR_MAX : year_ff - 14'd1;
                  day_in   = DAY_DEC_LAST;
               end else begin
                  // The year is unchanged, so the current leap flag applies.
                  month_in = month_ff - 4'd1;
                  day_in   = cds_month_days(leap_cur, month_ff - 4'd1);
               end
            end else begin
               day_in = day_ff - 5'd1;
            end
         end
         default: begin
            // Unused command: date unchanged, no error.
         end
      endcase
   end

   // The result item reports the stored date after the update.
   always_comb begin
      rsp_in.year       = year_ff;
      rsp_in.month      = month_ff;
      rsp_in.day        = day_ff;
      rsp_in.leap_year  = leap_cur;
      rsp_in.load_error = err_ff;
   end

   // State and stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff        <= RESET_YEAR;
         month_ff       <= RESET_MONTH;
         day_ff         <= RESET_DAY;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            year_ff  <= year_in;
            month_ff <= month_in;
            day_ff   <= day_in;
         end
         if (req_if.ready) begin
            stage_valid_ff <= req_take;
         end
         if (rsp_free) begin
            rsp_valid_ff <= stage_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         err_ff <= err_in;
      end
      if (stage_move) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // The stored date is always a real date.
   assert property (@(posedge clock) disable iff (reset)
      (month_ff >= MONTH_FIRST) && (month_ff <= MONTH_LAST)
      && (day_ff >= DAY_FIRST) && (day_ff <= len_cur) && (year_ff <= YEAR_MAX))
      else $error("stored date is not a valid date");

   // A refused load leaves the date untouched.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req.cmd == CMD_LOAD && !load_ok)
      |=> ($stable(year_ff) && $stable(month_ff) && $stable(day_ff) && err_ff))
      else $error("refused load changed the date");

   // A first-stage item that cannot move on keeps the date frozen.
   assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !rsp_free)
      |=> (stage_valid_ff && $stable(year_ff) && $stable(month_ff) && $stable(day_ff)))
      else $error("date changed while its item was stalled");

   // An advance always moves the date, so one day never repeats.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req.cmd == CMD_NEXT) |=> !$stable(day_ff))
      else $error("advance left the day unchanged");
`endif

endmodule
